/* rtl/core/gskl_pkg.sv */
`timescale 1ns / 1ps

package gskl_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // Operand and product widths of the shared multiplier
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;

    // Denominator 2*pv*qv needs 65 bits (field is 66 wide)
    localparam int DEN_W = 66;

    // Result field
    localparam int DIST_W = 48;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Quotient bits the divider resolves; a larger quotient is flagged as overflow
    localparam int QUO_W = DIST_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_DV,
        ST_PQ,
        ST_SQ_AD,
        ST_LO,
        ST_HI,
        ST_ADD,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_ACC
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic ovf;
    } div_stat_t;

endpackage

/* rtl/core/gskl_mul.sv */
`timescale 1ns / 1ps

module gskl_mul (
    input  logic                          aclk,
    input  logic [gskl_pkg::MUL_W-1:0]    op_a,
    input  logic [gskl_pkg::MUL_W-1:0]    op_b,
    output logic [gskl_pkg::PROD_W-1:0]   prod
);

    logic [gskl_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

/* rtl/core/gskl_div.sv */
`timescale 1ns / 1ps

module gskl_div #(
    parameter int NUM_W = 99
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [NUM_W-1:0]              num,
    input  logic [gskl_pkg::DEN_W-1:0]    den,
    output logic [gskl_pkg::QUO_W-1:0]    quo,
    output gskl_pkg::div_stat_t           stat
);

    localparam int QW    = gskl_pkg::QUO_W;
    localparam int DW    = gskl_pkg::DEN_W;
    localparam int CNT_W = $clog2(QW);

    logic [DW-1:0]    rem_reg;
    logic [QW-1:0]    nsh_reg;
    logic [QW-1:0]    quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             ovf_reg;

    logic [DW:0] rem_init;
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        fits;

    // Top numerator bits as the starting remainder: if they reach the
    // divisor the quotient cannot fit in QW bits
    assign rem_init = (DW+1)'(num[NUM_W-1:QW]);
    assign trial    = {rem_reg, nsh_reg[QW-1]};
    assign diff     = trial - {1'b0, den};
    assign fits     = (trial >= {1'b0, den});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ovf_reg  <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            if (rem_init >= {1'b0, den}) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
                ovf_reg  <= 1'b1;
            end else begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                ovf_reg  <= 1'b0;
            end
            cnt_reg <= CNT_W'(QW - 1);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= rem_init[DW-1:0];
            nsh_reg <= num[QW-1:0];
            quo_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[DW-1:0] : trial[DW-1:0];
            nsh_reg <= {nsh_reg[QW-2:0], 1'b0};
            quo_reg <= {quo_reg[QW-2:0], fits};
        end
    end

    assign quo       = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.ovf  = ovf_reg;

endmodule

/* rtl/core/gaussian_symmetric_kl_distance_top.sv */
`timescale 1ns / 1ps
// An item runs through five products on the shared 33x33 multiplier, then the
// 48-step radix-2 divider (skipped when the term saturates early), then the
// accumulate step, which holds on the last dimension until the result register
// is free. One item at a time: input is not ready again until the item is done.
// Reset: synchronous, active low; clears the running sum and overflow flag.
module gaussian_symmetric_kl_distance_top #(
    parameter int FRAC_BITS = gskl_pkg::FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [31:0]            s_mean_a,
    input  logic [31:0]                   s_var_a,
    input  logic signed [31:0]            s_mean_b,
    input  logic [31:0]                   s_var_b,
    input  logic                          s_last_dim,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [gskl_pkg::DIST_W-1:0]   m_distance,
    output logic                          m_saturated
);

    localparam int MW     = gskl_pkg::MUL_W;
    localparam int PW     = gskl_pkg::PROD_W;
    localparam int DW     = gskl_pkg::DEN_W;
    localparam int OW     = gskl_pkg::DIST_W;
    localparam int T1_W   = 64 + FRAC_BITS;
    localparam int NUM_W  = ((T1_W > 98) ? T1_W : 98) + 1;

    gskl_pkg::state_t state_reg, state_next;

    logic [31:0]    pv_reg, qv_reg, dv_reg;
    logic [MW-1:0]  ad_reg, s_reg;
    logic           last_reg;
    logic [PW-2:0]  sq_reg;
    logic [NUM_W-1:0] num_reg;
    logic [DW-1:0]  den_reg;

    logic [OW-1:0]  sum_reg;
    logic           ovf_reg;
    logic           m_valid_reg;
    logic [OW-1:0]  m_distance_reg;
    logic           m_saturated_reg;

    logic [MW-1:0]  mul_a, mul_b;
    logic [PW-1:0]  prod;

    logic                   div_start;
    logic [OW-1:0]          quo;
    gskl_pkg::div_stat_t    div_stat;

    logic signed [33:0] d_in;
    logic [33:0]        ad_in;
    logic [31:0]        pv_in, qv_in;

    logic [OW-1:0] term;
    logic          term_sat;
    logic [OW:0]   sum_wide;
    logic          sum_sat;
    logic          out_free;

    gskl_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    gskl_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_reg),
        .den     (den_reg),
        .quo     (quo),
        .stat    (div_stat)
    );

    // Input conditioning: floor variances, offset mean difference by one LSB
    assign d_in  = 34'(s_mean_a) - 34'(s_mean_b) + 34'sd1;
    assign ad_in = d_in[33] ? 34'(-d_in) : 34'(d_in);
    assign pv_in = (s_var_a == '0) ? 32'd1 : s_var_a;
    assign qv_in = (s_var_b == '0) ? 32'd1 : s_var_b;

    // Term clamp and running sum saturation
    assign term_sat = div_stat.ovf || (quo == gskl_pkg::DIST_MAX);
    assign term     = term_sat ? gskl_pkg::DIST_MAX : quo;
    assign sum_wide = {1'b0, sum_reg} + {1'b0, term};
    assign sum_sat  = (sum_wide >= {1'b0, gskl_pkg::DIST_MAX});
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        mul_a      = '0;
        mul_b      = '0;
        div_start  = 1'b0;
        unique case (state_reg)
            gskl_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = gskl_pkg::ST_SQ_DV;
                end
            end
            gskl_pkg::ST_SQ_DV: begin
                mul_a      = MW'(dv_reg);
                mul_b      = MW'(dv_reg);
                state_next = gskl_pkg::ST_PQ;
            end
            gskl_pkg::ST_PQ: begin
                mul_a      = MW'(pv_reg);
                mul_b      = MW'(qv_reg);
                state_next = gskl_pkg::ST_SQ_AD;
            end
            gskl_pkg::ST_SQ_AD: begin
                mul_a      = ad_reg;
                mul_b      = ad_reg;
                state_next = gskl_pkg::ST_LO;
            end
            gskl_pkg::ST_LO: begin
                mul_a      = prod[MW-1:0];
                mul_b      = s_reg;
                state_next = gskl_pkg::ST_HI;
            end
            gskl_pkg::ST_HI: begin
                mul_a      = MW'(sq_reg[PW-2:MW]);
                mul_b      = s_reg;
                state_next = gskl_pkg::ST_ADD;
            end
            gskl_pkg::ST_ADD: begin
                state_next = gskl_pkg::ST_DIV_GO;
            end
            gskl_pkg::ST_DIV_GO: begin
                div_start  = 1'b1;
                state_next = gskl_pkg::ST_DIV_WAIT;
            end
            gskl_pkg::ST_DIV_WAIT: begin
                if (div_stat.done) begin
                    state_next = gskl_pkg::ST_ACC;
                end
            end
            gskl_pkg::ST_ACC: begin
                // hold until the result register is free on the last dimension
                if (!last_reg || out_free) begin
                    state_next = gskl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = gskl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gskl_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Operand and numerator datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            gskl_pkg::ST_IDLE: begin
                if (s_valid) begin
                    pv_reg   <= pv_in;
                    qv_reg   <= qv_in;
                    dv_reg   <= (pv_in > qv_in) ? (pv_in - qv_in) : (qv_in - pv_in);
                    ad_reg   <= ad_in[MW-1:0];
                    s_reg    <= {1'b0, pv_in} + {1'b0, qv_in};
                    last_reg <= s_last_dim;
                end
            end
            gskl_pkg::ST_PQ: begin
                num_reg <= NUM_W'(prod) << FRAC_BITS;
            end
            gskl_pkg::ST_SQ_AD: begin
                den_reg <= {prod[DW-2:0], 1'b0};
            end
            gskl_pkg::ST_LO: begin
                sq_reg <= prod[PW-2:0];
            end
            gskl_pkg::ST_HI: begin
                num_reg <= num_reg + NUM_W'(prod);
            end
            gskl_pkg::ST_ADD: begin
                num_reg <= num_reg + (NUM_W'(prod) << MW);
            end
            default: begin
            end
        endcase
    end

    // Running sum, overflow flag and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg     <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready &&
                !(state_reg == gskl_pkg::ST_ACC && last_reg)) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == gskl_pkg::ST_ACC && (!last_reg || out_free)) begin
                if (last_reg) begin
                    m_valid_reg     <= 1'b1;
                    m_distance_reg  <= sum_sat ? gskl_pkg::DIST_MAX : sum_wide[OW-1:0];
                    m_saturated_reg <= ovf_reg || term_sat ||
                                       (sum_sat && (sum_wide[OW] || term_sat));
                    sum_reg         <= '0;
                    ovf_reg         <= 1'b0;
                end else begin
                    sum_reg <= sum_sat ? gskl_pkg::DIST_MAX : sum_wide[OW-1:0];
                    ovf_reg <= ovf_reg || term_sat || (sum_sat && sum_wide[OW]);
                end
            end
        end
    end

    assign s_ready     = (state_reg == gskl_pkg::ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_distance  = m_distance_reg;
    assign m_saturated = m_saturated_reg;

    a_sum_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        sum_reg <= gskl_pkg::DIST_MAX)
        else $error("running sum above saturation limit");

    a_ready_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !div_stat.busy)
        else $error("input ready while divider busy");

    a_emit_from_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == gskl_pkg::ST_ACC) && $past(last_reg))
        else $error("result raised outside accumulate step");

    a_div_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == gskl_pkg::ST_ACC) |-> div_stat.done)
        else $error("accumulate without a finished division");

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam int          NUM_RANDOM = 1000;
    localparam int          CALM_TAIL  = 100;
    localparam int          DRAIN_WAIT = 120;
    localparam logic [63:0] SUM_CAP    = 64'(gskl_pkg::DIST_MAX);

    typedef struct {
        logic signed [31:0] mean_a;
        logic [31:0]        var_a;
        logic signed [31:0] mean_b;
        logic [31:0]        var_b;
        logic               last_dim;
    } dim_t;

    typedef struct {
        logic [gskl_pkg::DIST_W-1:0] distance;
        logic                        saturated;
    } dist_t;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic signed [31:0]          s_mean_a = '0;
    logic [31:0]                 s_var_a = '0;
    logic signed [31:0]          s_mean_b = '0;
    logic [31:0]                 s_var_b = '0;
    logic                        s_last_dim = 1'b0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic [gskl_pkg::DIST_W-1:0] m_distance;
    logic                        m_saturated;

    dim_t  dim_q[$];
    dist_t dist_q[$];

    // Predictor state
    logic [63:0] sum_acc = '0;
    logic        ovf_acc = 1'b0;

    bit    s_taken = 1'b0;
    int    s_gap = 0;
    int    m_gap = 0;
    int    n_items = 0;
    int    n_accepted = 0;
    int    n_results = 0;
    int    n_sat = 0;
    int    n_errors = 0;
    dim_t  nxt;
    dist_t want;

    gaussian_symmetric_kl_distance_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mean_a    (s_mean_a),
        .s_var_a     (s_var_a),
        .s_mean_b    (s_mean_b),
        .s_var_b     (s_var_b),
        .s_last_dim  (s_last_dim),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_distance  (m_distance),
        .m_saturated (m_saturated)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Add one dimension's term to the running distance; queue the sum on the last one
    function automatic void accumulate_dimension(dim_t it);
        logic signed [33:0] diff;
        logic [33:0]        mag;
        logic [31:0]        pv, qv, dv;
        logic [127:0]       num, den, quo;
        logic [63:0]        term;
        diff = $signed({{2{it.mean_a[31]}}, it.mean_a})
             - $signed({{2{it.mean_b[31]}}, it.mean_b}) + 34'sd1;
        mag  = diff[33] ? -diff : diff;
        pv   = (it.var_a == '0) ? 32'd1 : it.var_a;
        qv   = (it.var_b == '0) ? 32'd1 : it.var_b;
        dv   = (pv > qv) ? pv - qv : qv - pv;
        num  = (128'(dv) * 128'(dv)) << gskl_pkg::FRAC_BITS_DEF;
        num  = num + 128'(mag) * 128'(mag) * (128'(pv) + 128'(qv));
        den  = 128'(pv) * 128'(qv) * 128'd2;
        quo  = num / den;
        if (quo >= 128'(SUM_CAP)) begin
            term    = SUM_CAP;
            ovf_acc = 1'b1;
        end else begin
            term = quo[63:0];
        end
        sum_acc = sum_acc + term;
        if (sum_acc >= SUM_CAP) begin
            if (sum_acc > SUM_CAP || term == SUM_CAP)
                ovf_acc = 1'b1;
            sum_acc = SUM_CAP;
        end
        if (it.last_dim) begin
            dist_q.push_back('{sum_acc[gskl_pkg::DIST_W-1:0], ovf_acc});
            sum_acc = '0;
            ovf_acc = 1'b0;
        end
    endfunction

    task automatic add_dim(input logic [31:0] ma, input logic [31:0] va,
                           input logic [31:0] mb, input logic [31:0] vb,
                           input logic last);
        dim_q.push_back('{ma, va, mb, vb, last});
        n_items++;
    endtask

    function automatic logic [31:0] pick_var();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return 32'hFFFF_FFFF;
            3, 4:    return $urandom_range(1, 32'h0004_0000);
            5, 6:    return 32'h0001_0000 + $urandom_range(0, 32'h0000_FFFF);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_mean();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3:    return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            default: return $urandom();
        endcase
    endfunction

    task automatic build_stimulus();
        int          len;
        logic [31:0] ma, mb;
        // Smallest inputs: equal means, one LSB apart after the offset; variances floored, then equal
        add_dim(32'd0, 32'd0, 32'd0, 32'd0, 1'b1);
        add_dim(32'd0, 32'h0001_0000, 32'd0, 32'h0001_0000, 1'b1);
        // Extreme means: the term clamps with floored variances, not with the largest ones
        add_dim(32'h7FFF_FFFF, 32'd0, 32'h8000_0000, 32'd0, 1'b1);
        add_dim(32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        // Three large but unclamped terms push the sum over the top
        add_dim(32'd0, 32'hFFFF_FFFF, 32'd0, 32'd1, 1'b0);
        add_dim(32'd0, 32'hFFFF_FFFF, 32'd0, 32'd1, 1'b0);
        add_dim(32'd0, 32'd1, 32'd0, 32'hFFFF_FFFF, 1'b1);
        add_dim(32'hFFFF_FFFF, 32'd1, 32'd0, 32'hFFFF_FFFF, 1'b1);
        add_dim(32'h0001_8000, 32'h0000_4000, 32'hFFFF_0000, 32'h0002_0000, 1'b0);
        add_dim(32'h0000_0000, 32'h0001_0000, 32'h0000_8000, 32'h0000_C000, 1'b0);
        add_dim(32'hFFFE_0000, 32'h0003_0000, 32'hFFFE_4000, 32'h0001_0000, 1'b0);
        add_dim(32'h0010_0000, 32'h0000_0100, 32'h000F_0000, 32'h0000_0200, 1'b1);
        // Large but unclamped term mid-vector, then a vector holding only the small one
        add_dim(32'h7FFF_FFFF, 32'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        add_dim(32'h0000_1000, 32'h0001_0000, 32'h0000_0000, 32'h0001_0000, 1'b1);
        add_dim(32'h0000_1000, 32'h0001_0000, 32'h0000_0000, 32'h0001_0000, 1'b1);

        while (n_items < 15 + NUM_RANDOM) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 30) : $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
                ma = pick_mean();
                // Mostly nearby means, as for two similar models
                if ($urandom_range(0, 2) != 0)
                    mb = ma + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
                else
                    mb = pick_mean();
                add_dim(ma, pick_var(), mb, pick_var(), i == len - 1);
            end
        end
    endtask

    // Sample both channels; predict on input transactions, check on output transactions
    always @(posedge aclk) begin
        s_taken = aresetn && s_valid && s_ready;
        if (s_taken) begin
            accumulate_dimension('{s_mean_a, s_var_a, s_mean_b, s_var_b, s_last_dim});
            n_accepted++;
        end
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (m_saturated)
                n_sat++;
            if (dist_q.size() == 0) begin
                $display("%0t: result with none pending: distance=%h saturated=%b",
                         $time, m_distance, m_saturated);
                n_errors++;
            end else begin
                want = dist_q.pop_front();
                if (m_distance !== want.distance) begin
                    $display("%0t: distance mismatch: expected %h, actual %h",
                             $time, want.distance, m_distance);
                    n_errors++;
                end
                if (m_saturated !== want.saturated) begin
                    $display("%0t: saturated mismatch: expected %b, actual %b",
                             $time, want.saturated, m_saturated);
                    n_errors++;
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_taken) begin
            if (s_gap > 0) begin
                s_gap   <= s_gap - 1;
                s_valid <= 1'b0;
            end else if (dim_q.size() > 0) begin
                nxt = dim_q.pop_front();
                s_valid    <= 1'b1;
                s_mean_a   <= nxt.mean_a;
                s_var_a    <= nxt.var_a;
                s_mean_b   <= nxt.mean_b;
                s_var_b    <= nxt.var_b;
                s_last_dim <= nxt.last_dim;
                if (dim_q.size() > CALM_TAIL && $urandom_range(0, 5) == 0)
                    s_gap <= $urandom_range(1, 19);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (m_gap > 0) begin
            m_ready <= 1'b0;
            m_gap   <= m_gap - 1;
        end else begin
            m_ready <= 1'b1;
            if (dim_q.size() > CALM_TAIL && $urandom_range(0, 9) == 0)
                m_gap <= $urandom_range(1, 19);
        end
    end

    initial begin
        build_stimulus();
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        wait (n_accepted == n_items);
        wait (dist_q.size() == 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
        $display("Covered %0d dimensions, %0d distances returned, %0d of them saturated.",
                 n_accepted, n_results, n_sat);
        if (n_errors == 0) begin
            $display("gaussian_symmetric_kl_distance_top regression: pass");
        end else begin
            $display("gaussian_symmetric_kl_distance_top regression: fail");
        end
        $finish;
    end

    initial begin
        #12_000_000;
        $display("Timed out with %0d of %0d dimensions accepted.", n_accepted, n_items);
        $display("gaussian_symmetric_kl_distance_top regression: fail");
        $finish;
    end

endmodule

/* gaussian_symmetric_kl_distance_top.f */
rtl/core/gskl_pkg.sv
rtl/core/gskl_mul.sv
rtl/core/gskl_div.sv
rtl/core/gaussian_symmetric_kl_distance_top.sv
verif/tb.sv
